>>> src/rmir_pkg.sv
// shared types, constants and crc helper for the image receiver
`timescale 1ns / 1ps
package rmir_pkg;

   localparam int WINDOW_WORDS   = 128;
   localparam int WIN_IDX_W      = $clog2(WINDOW_WORDS);
   localparam int COUNT_W        = 23;
   localparam logic [31:0] IMAGE_CAPACITY = 32'd4194304;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [7:0] ADDR_CONTROL  = 8'd0;
   localparam logic [7:0] ADDR_SIZE_HI  = 8'd1;
   localparam logic [7:0] ADDR_SIZE_LO  = 8'd2;
   localparam logic [7:0] ADDR_CRC_HI   = 8'd3;
   localparam logic [7:0] ADDR_CRC_LO   = 8'd4;
   localparam logic [7:0] ADDR_VERSION  = 8'd5;
   localparam logic [7:0] ADDR_WIN_BASE = 8'h10;

   localparam logic [15:0] CMD_START  = 16'd1;
   localparam logic [15:0] CMD_COMMIT = 16'd2;
   localparam logic [15:0] CMD_ABORT  = 16'd3;
   localparam logic [15:0] CMD_CHUNK  = 16'h10;

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_RECEIVING  = 3'd1;
   localparam logic [2:0] ST_VALIDATING = 3'd2;
   localparam logic [2:0] ST_SUCCESS    = 3'd3;
   localparam logic [2:0] ST_ERROR      = 3'd4;

   localparam logic       ACC_READ  = 1'b0;
   localparam logic       ACC_WRITE = 1'b1;

   localparam logic [15:0] FW_VERSION_RESET = 16'h0100;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  reg_addr;
      logic [15:0] write_data;
   } req_type_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [2:0]  status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic feed_hi;
      logic feed_lo;
      logic next_word;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_chunk;
      logic below_limit;
      logic last_word;
   } stat_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> src/rmir_ctrl.sv
// sequencer for register accesses and chunk walks
`timescale 1ns / 1ps
module rmir_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rmir_pkg::stat_type   stat,
   output rmir_pkg::cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_HI   = 2'd1;
   localparam logic [1:0] S_LO   = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (stat.is_chunk) state_in = S_HI;
            end
         end
         S_HI: begin
            if (stat.below_limit) begin
               cmd.feed_hi = 1'b1;
               state_in = S_LO;
            end else begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_LO: begin
            cmd.feed_lo = stat.below_limit;
            if (stat.last_word) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.next_word = 1'b1;
               state_in = S_HI;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> src/rmir_dp.sv
// registers, window memory, crc and byte count
`timescale 1ns / 1ps
module rmir_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  rmir_pkg::req_type_type req,
   input  rmir_pkg::cmd_type      cmd,
   output rmir_pkg::stat_type     stat,
   input  logic                   csr_valid,
   input  logic [15:0]            csr_write_data,
   output logic                   rsp_strobe,
   output rmir_pkg::rsp_type      rsp
);

   localparam int IW = rmir_pkg::WIN_IDX_W;
   localparam int CW = rmir_pkg::COUNT_W;

   logic [15:0] fw_version_ff;
   logic        receiving_ff, receiving_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] tcrc_ff, tcrc_in;
   logic [31:0] crc_ff, crc_in;
   logic [2:0]  status_ff, status_in;

   logic [15:0] win_mem [rmir_pkg::WINDOW_WORDS];
   logic [rmir_pkg::WINDOW_WORDS-1:0] win_valid_ff;
   logic [15:0] word_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] rd_idx;

   logic        rsp_strobe_ff, rsp_strobe_in;
   rmir_pkg::rsp_type rsp_ff, rsp_in;

   logic          is_wr;
   logic [8:0]    win_off;
   logic          win_hit;
   logic [CW-1:0] limit;

   assign is_wr   = (req.req_type == rmir_pkg::ACC_WRITE);
   assign win_off = {1'b0, req.reg_addr} - {1'b0, rmir_pkg::ADDR_WIN_BASE};
   assign win_hit = (req.reg_addr >= rmir_pkg::ADDR_WIN_BASE)
                    && (win_off < 9'(rmir_pkg::WINDOW_WORDS));
   assign limit   = (size_ff > rmir_pkg::IMAGE_CAPACITY) ? rmir_pkg::IMAGE_CAPACITY[CW-1:0]
                                                         : size_ff[CW-1:0];

   assign stat.is_chunk    = is_wr && (req.reg_addr == rmir_pkg::ADDR_CONTROL)
                             && (req.write_data >= rmir_pkg::CMD_CHUNK) && receiving_ff;
   assign stat.below_limit = ({{(32-CW){1'b0}}, count_ff} < {{(32-CW){1'b0}}, limit});
   assign stat.last_word   = (idx_ff == IW'(rmir_pkg::WINDOW_WORDS - 1));

   // the word is held through both byte steps, the next one is fetched on the word step
   assign rd_idx = cmd.accept ? '0 : (cmd.next_word ? idx_ff + 1'b1 : idx_ff);

   always_comb begin
      receiving_in  = receiving_ff;
      count_in      = count_ff;
      size_in       = size_ff;
      tcrc_in       = tcrc_ff;
      crc_in        = crc_ff;
      status_in     = status_ff;
      idx_in        = idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      if (cmd.accept) begin
         rsp_in.read_data = '0;
         if (is_wr) begin
            case (req.reg_addr)
               rmir_pkg::ADDR_CONTROL: begin
                  if (req.write_data == rmir_pkg::CMD_START) begin
                     count_in     = '0;
                     crc_in       = rmir_pkg::CRC_INIT;
                     receiving_in = 1'b1;
                     status_in    = rmir_pkg::ST_RECEIVING;
                  end else if (req.write_data == rmir_pkg::CMD_COMMIT) begin
                     receiving_in = 1'b0;
                     status_in = ((~crc_ff) == tcrc_ff && {{(32-CW){1'b0}}, count_ff} == size_ff)
                                 ? rmir_pkg::ST_SUCCESS : rmir_pkg::ST_ERROR;
                  end else if (req.write_data == rmir_pkg::CMD_ABORT) begin
                     receiving_in = 1'b0;
                     status_in    = rmir_pkg::ST_IDLE;
                  end else if (stat.is_chunk) begin
                     status_in = rmir_pkg::ST_RECEIVING;
                     idx_in    = '0;
                  end
               end
               rmir_pkg::ADDR_SIZE_HI: size_in = {req.write_data, size_ff[15:0]};
               rmir_pkg::ADDR_SIZE_LO: size_in = {size_ff[31:16], req.write_data};
               rmir_pkg::ADDR_CRC_HI:  tcrc_in = {req.write_data, tcrc_ff[15:0]};
               rmir_pkg::ADDR_CRC_LO:  tcrc_in = {tcrc_ff[31:16], req.write_data};
               default: ;
            endcase
         end else begin
            if (req.reg_addr == rmir_pkg::ADDR_CONTROL)
               rsp_in.read_data = {13'd0, status_ff};
            else if (req.reg_addr == rmir_pkg::ADDR_VERSION)
               rsp_in.read_data = fw_version_ff;
         end
         rsp_in.status = status_in;
         rsp_strobe_in = !stat.is_chunk;
      end
      if (cmd.feed_hi) begin
         crc_in   = rmir_pkg::crc_byte(crc_ff, word_ff[15:8]);
         count_in = count_ff + 1'b1;
      end
      if (cmd.feed_lo) begin
         crc_in   = rmir_pkg::crc_byte(crc_ff, word_ff[7:0]);
         count_in = count_ff + 1'b1;
      end
      if (cmd.next_word) idx_in = idx_ff + 1'b1;
      if (cmd.finish) begin
         rsp_strobe_in    = 1'b1;
         rsp_in.read_data = '0;
         rsp_in.status    = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_version_ff <= rmir_pkg::FW_VERSION_RESET;
         receiving_ff  <= 1'b0;
         count_ff      <= '0;
         size_ff       <= '0;
         tcrc_ff       <= '0;
         crc_ff        <= rmir_pkg::CRC_INIT;
         status_ff     <= rmir_pkg::ST_IDLE;
         win_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_valid) fw_version_ff <= csr_write_data;
         receiving_ff  <= receiving_in;
         count_ff      <= count_in;
         size_ff       <= size_in;
         tcrc_ff       <= tcrc_in;
         crc_ff        <= crc_in;
         status_ff     <= status_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (cmd.accept && is_wr && win_hit) win_valid_ff[win_off[IW-1:0]] <= 1'b1;
      end
   end

   // window memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.accept && is_wr && win_hit) win_mem[win_off[IW-1:0]] <= req.write_data;
      word_ff <= win_valid_ff[rd_idx] ? win_mem[rd_idx] : 16'd0;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

endmodule

>>> src/register_mapped_image_receiver_crc32.sv
// top level of the register-mapped image receiver with crc-32
`timescale 1ns / 1ps
// register accesses are taken when start is high and busy is low. a plain read
// or write shows its result on rsp_payload, marked by rsp_strobe, for one cycle
// on the next clock; the receiver cannot stall, so every result must be captured
// then. a chunk-ready write while receiving holds busy while the sequencer walks
// the 128-word window one byte a cycle through the crc, a high and a low byte
// step per word, ending early when the expected size is reached; its result
// follows the last byte. the version register is written on the csr channel,
// which is always ready
module register_mapped_image_receiver_crc32 (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  rmir_pkg::req_type_type req_payload,
   // result channel
   output logic                   rsp_strobe,
   output rmir_pkg::rsp_type      rsp_payload,
   // version register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_write_data
);

   rmir_pkg::cmd_type  cmd;
   rmir_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   // state machine: idle, then high and low byte steps of each window word
   rmir_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // register file, window store, crc and count
   rmir_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req            (req_payload),
      .cmd            (cmd),
      .stat           (stat),
      .csr_valid      (csr_valid),
      .csr_write_data (csr_write_data),
      .rsp_strobe     (rsp_strobe),
      .rsp            (rsp_payload)
   );

`ifndef SYNTHESIS
   // every accepted transfer either answers next cycle or starts a walk
   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe || busy)
      else $error("accepted transfer neither answered nor started a chunk walk");

   // a walk always ends with its result, shown in the cycle in which busy drops
   a_walk_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("chunk walk ended without a result");

   // busy only rises from an accepted transfer
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without an accepted transfer");
`endif

endmodule
